// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape core.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	// Result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_QUOTE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Input actions
	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Most results one input can cause
	localparam int unsigned MAX_RES = 8;
	localparam int unsigned RES_IW  = $clog2(MAX_RES);
	localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);

	// Characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_HEX,
		MODE_HIGH,
		MODE_HIGH_ESC,
		MODE_HIGH_HEX
	} mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] ent;
		logic [RES_CW-1:0]  cnt;
	} burst_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hex_value;
		logic [1:0]  hex_count;
		logic [9:0]  high_half;
		logic        high_pending;
	} dec_state_t;

	localparam dec_state_t DEC_RESET = '{
		mode:         MODE_NORMAL,
		hex_value:    16'h0000,
		hex_count:    2'd0,
		high_half:    10'd0,
		high_pending: 1'b0
	};

endpackage

`default_nettype wire

// File: hdl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: raw string body bytes and the end-of-text command.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_byte;

	modport source (output valid, output action, output in_byte, input ready);
	modport sink   (input valid, input action, input in_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: decoded UTF-8 bytes and string markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Single-pass decode of one input item against the held state.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode import jsu_pkg::*; (
	input  wire logic       action,
	input  wire logic [7:0] in_byte,
	input  wire dec_state_t st,
	input  wire logic [7:0] raw [3],
	output dec_state_t      nxt,
	output logic            raw_we,
	output logic [1:0]      raw_idx,
	output logic [7:0]      raw_data,
	output burst_t          res
);

	typedef enum logic [2:0] {T_NONE, T_BYTE, T_QUOTE, T_UTF8, T_END} tail_t;

	typedef struct packed {
		mode_t      mode;
		tail_t      tail;
		logic [7:0] tbyte;
	} step_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} utf8_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)      h.val = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) h.val = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) h.val = 4'(c - 8'h37);
		else                               h.ok  = 1'b0;
		return h;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] code);
		utf8_t u;
		u.bytes = '0;
		if (code < 21'h80) begin
			u.len      = 3'd1;
			u.bytes[0] = code[7:0];
		end else if (code < 21'h800) begin
			u.len      = 3'd2;
			u.bytes[0] = {3'b110, code[10:6]};
			u.bytes[1] = {2'b10, code[5:0]};
		end else if (code < 21'h10000) begin
			u.len      = 3'd3;
			u.bytes[0] = {4'b1110, code[15:12]};
			u.bytes[1] = {2'b10, code[11:6]};
			u.bytes[2] = {2'b10, code[5:0]};
		end else begin
			u.len      = 3'd4;
			u.bytes[0] = {5'b11110, code[20:18]};
			u.bytes[1] = {2'b10, code[17:12]};
			u.bytes[2] = {2'b10, code[11:6]};
			u.bytes[3] = {2'b10, code[5:0]};
		end
		return u;
	endfunction

	function automatic step_t normal_step(input logic [7:0] c);
		step_t s;
		s.tbyte = c;
		s.mode  = (c == CH_BSL) ? MODE_ESC : MODE_NORMAL;
		if (c == CH_QUOTE)    s.tail = T_QUOTE;
		else if (c == CH_BSL) s.tail = T_NONE;
		else                  s.tail = T_BYTE;
		return s;
	endfunction

	function automatic step_t escape_step(input logic [7:0] c);
		step_t s;
		s.mode = MODE_NORMAL;
		s.tail = T_BYTE;
		case (c)
			8'h6E:   s.tbyte = 8'h0A;
			8'h74:   s.tbyte = 8'h09;
			8'h72:   s.tbyte = 8'h0D;
			8'h62:   s.tbyte = 8'h08;
			8'h66:   s.tbyte = 8'h0C;
			default: s.tbyte = c;
		endcase
		if (c == CH_U) begin
			s.mode = MODE_HEX;
			s.tail = T_NONE;
		end
		return s;
	endfunction

	hex_t        hd;
	logic        full;
	logic [15:0] unit;
	logic        unit_high;
	logic        unit_low;
	logic        drop;
	logic        rawu;
	logic        bsl;
	step_t       stp;
	logic [20:0] tail_code;
	utf8_t       enc;
	utf8_t       fffd;
	logic [RES_CW-1:0] cnt;

	assign hd        = hex_digit(in_byte);
	assign full      = hd.ok && (st.hex_count == 2'd3);
	assign unit      = {st.hex_value[11:0], hd.val};
	assign unit_high = (unit >= 16'hD800) && (unit <= 16'hDBFF);
	assign unit_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
	assign fffd      = utf8_enc(21'h00FFFD);

	// State update and choice of emitted segments
	always_comb begin
		nxt       = st;
		raw_we    = 1'b0;
		raw_idx   = st.hex_count;
		raw_data  = in_byte;
		drop      = 1'b0;
		rawu      = 1'b0;
		bsl       = 1'b0;
		stp       = '{mode: MODE_NORMAL, tail: T_NONE, tbyte: in_byte};
		tail_code = '0;

		if (action == ACT_END) begin
			unique case (st.mode)
				MODE_ESC:      bsl  = 1'b1;
				MODE_HEX:      rawu = 1'b1;
				MODE_HIGH:     drop = 1'b1;
				MODE_HIGH_ESC: begin
					drop = 1'b1;
					bsl  = 1'b1;
				end
				MODE_HIGH_HEX: begin
					drop = 1'b1;
					rawu = 1'b1;
				end
				default: ;
			endcase
			stp.tail = T_END;
			nxt      = DEC_RESET;
		end else begin
			unique case (st.mode)
				MODE_ESC: stp = escape_step(in_byte);
				MODE_HEX, MODE_HIGH_HEX: begin
					stp.mode = st.mode;
					if (!hd.ok) begin
						drop = (st.mode == MODE_HIGH_HEX);
						rawu = 1'b1;
						stp  = normal_step(in_byte);
					end else if (!full) begin
						nxt.hex_value = unit;
						nxt.hex_count = st.hex_count + 2'd1;
						raw_we        = 1'b1;
					end else begin
						nxt.hex_value = '0;
						nxt.hex_count = 2'd0;
						if (st.mode == MODE_HIGH_HEX && unit_low) begin
							// Surrogate pair: 0x10000 + (high << 10) + low
							stp.mode  = MODE_NORMAL;
							stp.tail  = T_UTF8;
							tail_code = {({1'b0, st.high_half} + 11'd64), unit[9:0]};
						end else begin
							drop     = (st.mode == MODE_HIGH_HEX);
							stp.mode = MODE_NORMAL;
							if (unit_high) begin
								stp.mode = MODE_HIGH;
							end else if (unit_low) begin
								stp.tail  = T_UTF8;
								tail_code = 21'h00FFFD;
							end else begin
								stp.tail  = T_UTF8;
								tail_code = {5'd0, unit};
							end
						end
					end
				end
				MODE_HIGH: begin
					if (in_byte == CH_BSL) begin
						stp.mode = MODE_HIGH_ESC;
					end else begin
						drop = 1'b1;
						stp  = normal_step(in_byte);
					end
				end
				MODE_HIGH_ESC: begin
					if (in_byte == CH_U) begin
						stp.mode = MODE_HIGH_HEX;
					end else begin
						drop = 1'b1;
						stp  = escape_step(in_byte);
					end
				end
				default: stp = normal_step(in_byte);
			endcase

			nxt.mode = stp.mode;
			if (rawu) begin
				nxt.hex_value = '0;
				nxt.hex_count = 2'd0;
			end
			if ((stp.mode == MODE_HEX || stp.mode == MODE_HIGH_HEX) &&
			    st.mode != MODE_HEX && st.mode != MODE_HIGH_HEX) begin
				nxt.hex_value = '0;
				nxt.hex_count = 2'd0;
			end
			if (drop || (stp.mode == MODE_NORMAL && stp.tail == T_UTF8 &&
			    st.mode == MODE_HIGH_HEX)) begin
				nxt.high_half    = '0;
				nxt.high_pending = 1'b0;
			end
			if (stp.mode == MODE_HIGH && st.mode != MODE_HIGH) begin
				nxt.high_half    = unit[9:0];
				nxt.high_pending = 1'b1;
			end
		end
	end

	assign enc = utf8_enc(tail_code);

	// Assemble results in order: replacement char, raw digits, backslash, tail
	always_comb begin
		res.ent = '0;
		cnt     = '0;
		if (drop) begin
			for (int i = 0; i < 3; i++) begin
				res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: fffd.bytes[i]};
				cnt = cnt + RES_CW'(1);
			end
		end
		if (rawu) begin
			res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: CH_U};
			cnt = cnt + RES_CW'(1);
			for (int i = 0; i < 3; i++) begin
				if (i < int'(st.hex_count)) begin
					res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: raw[i]};
					cnt = cnt + RES_CW'(1);
				end
			end
		end
		if (bsl) begin
			res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: CH_BSL};
			cnt = cnt + RES_CW'(1);
		end
		case (stp.tail)
			T_BYTE: begin
				res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: stp.tbyte};
				cnt = cnt + RES_CW'(1);
			end
			T_QUOTE: begin
				res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_QUOTE, data: 8'h00};
				cnt = cnt + RES_CW'(1);
			end
			T_END: begin
				res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_END, data: 8'h00};
				cnt = cnt + RES_CW'(1);
			end
			T_UTF8: begin
				for (int i = 0; i < 4; i++) begin
					if (i < int'(enc.len)) begin
						res.ent[cnt[RES_IW-1:0]] = '{kind: KIND_BYTE, data: enc.bytes[i]};
						cnt = cnt + RES_CW'(1);
					end
				end
			end
			default: ;
		endcase
		res.cnt = cnt;
	end

endmodule

`default_nettype wire

// File: hdl/jsu_burst.sv
// ----------------------------------------------------------------------------
// jsu_burst
// Result register: holds the results of one item and drains them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_burst import jsu_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire burst_t ld,
	output logic        free,
	jsu_out_if.source   out_ch
);

	res_t              ent_q [MAX_RES];
	logic [RES_CW-1:0] n_q;
	logic [RES_CW-1:0] ptr_q;
	logic [RES_CW-1:0] ptr_nx;
	logic              xfer;
	res_t              cur;

	assign ptr_nx = ptr_q + RES_CW'(1);
	assign xfer   = out_ch.valid && out_ch.ready;
	assign free   = (ptr_q == n_q) || (xfer && ptr_nx == n_q);
	assign cur    = ent_q[ptr_q[RES_IW-1:0]];

	assign out_ch.valid    = (ptr_q != n_q);
	assign out_ch.kind     = cur.kind;
	assign out_ch.out_byte = cur.data;
	assign out_ch.last     = (ptr_nx == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ptr_q <= '0;
		end else if (load && free) begin
			n_q   <= ld.cnt;
			ptr_q <= '0;
		end else if (xfer) begin
			ptr_q <= ptr_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			for (int i = 0; i < MAX_RES; i++) begin
				ent_q[i] <= ld.ent[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body to UTF-8 decoder with surrogate pairing.
// ----------------------------------------------------------------------------
// Takes one body byte (or an end-of-text command) per transfer and gives the
// decoded UTF-8 bytes, closing-quote markers and an end marker, each result
// flagged with last on the final one its input caused. An input item sits in
// a one-entry input register, is decoded in one pass against the held escape
// state and is written, all its results at once, into an eight-entry result
// register that drains one result per cycle while out_ch.ready is high. An
// input is taken every cycle while each item gives at most one result and
// the output is ready; an item giving more results holds the following item
// until the result register has drained. Items that give no result (a
// backslash, a hex digit) also pass at one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_core import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch
);

	// Input register
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// Escape state
	dec_state_t st_q;
	logic [7:0] raw_digits_q [3];

	dec_state_t st_nx;
	logic       raw_we;
	logic [1:0] raw_idx;
	logic [7:0] raw_data;
	burst_t     dec_res;
	logic       free;
	logic       commit;

	// Commit the held item once the result register can take its results
	assign commit      = valid_s1 && free;
	assign in_ch.ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: load on transfer, no reset needed
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1 <= in_ch.action;
			byte_s1   <= in_ch.in_byte;
		end
	end

	jsu_decode u_decode (
		.action   (action_s1),
		.in_byte  (byte_s1),
		.st       (st_q),
		.raw      (raw_digits_q),
		.nxt      (st_nx),
		.raw_we   (raw_we),
		.raw_idx  (raw_idx),
		.raw_data (raw_data),
		.res      (dec_res)
	);

	// Advance the escape state only on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DEC_RESET;
		end else if (commit) begin
			st_q <= st_nx;
		end
	end

	// Raw hex digits, kept for the literal fallback; only read once written
	always_ff @(posedge clk) begin
		if (commit && raw_we) begin
			raw_digits_q[raw_idx] <= raw_data;
		end
	end

	jsu_burst u_burst (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (commit),
		.ld     (dec_res),
		.free   (free),
		.out_ch (out_ch)
	);

	// End of text always gives at least its marker
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit && action_s1 == ACT_END |-> dec_res.cnt != '0)
		else $error("end of text committed with no result");

	// End of text returns the decoder to plain text
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		commit && action_s1 == ACT_END |=> st_q.mode == MODE_NORMAL && !st_q.high_pending)
		else $error("state not cleared after end of text");

	// A held high surrogate goes with the surrogate modes and no other
	a_high_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.high_pending == (st_q.mode == MODE_HIGH || st_q.mode == MODE_HIGH_ESC ||
		                      st_q.mode == MODE_HIGH_HEX))
		else $error("high surrogate flag out of step with mode");

	// A held item waits only while the result register still drains
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !commit |-> out_ch.valid)
		else $error("input held with no results pending");

endmodule

`default_nettype wire
